>>> design/scc_pkg.sv
// shared types, widths and helpers for the segment crossing counter
// no dependencies; imported by every module of the block
package scc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  // coordinates are masked to COORD_BITS, ports are FIELD_W wide
  localparam int COORD_W    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SCORE_W    = 16;
  localparam int SUM_W      = 32;
  localparam int NUM_ORIENT = 4;

  localparam logic [SCORE_W-1:0] PENALTY_RESET = SCORE_W'(1);
  localparam logic [SCORE_W-1:0] SCORE_CROSS   = SCORE_W'(1);
  localparam logic [SCORE_W-1:0] SCORE_NONE    = '0;

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef enum logic [1:0] {
    ORI_ZERO,
    ORI_POS,
    ORI_NEG
  } orient_e;

  // registered cross products and box flags of one word
  typedef struct packed {
    prod_t [NUM_ORIENT-1:0]  lhs;
    prod_t [NUM_ORIENT-1:0]  rhs;
    logic  [NUM_ORIENT-1:0]  boxed;
    logic                    run_end;
  } stage_t;

  function automatic orient_e orient_of(prod_t a, prod_t b);
    orient_e o;
    if (a == b) begin
      o = ORI_ZERO;
    end else if ($signed(a) > $signed(b)) begin
      o = ORI_POS;
    end else begin
      o = ORI_NEG;
    end
    return o;
  endfunction

endpackage

>>> design/scc_pair_if.sv
// input channel of the segment crossing counter: two segments and a run-end mark
// depends on scc_pkg
interface scc_pair_if import scc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  query_start_x;
  logic [FIELD_W-1:0]  query_start_y;
  logic [FIELD_W-1:0]  query_end_x;
  logic [FIELD_W-1:0]  query_end_y;
  logic [FIELD_W-1:0]  cand_start_x;
  logic [FIELD_W-1:0]  cand_start_y;
  logic [FIELD_W-1:0]  cand_end_x;
  logic [FIELD_W-1:0]  cand_end_y;
  logic                run_end;

  modport source (
    output valid, query_start_x, query_start_y, query_end_x, query_end_y,
           cand_start_x, cand_start_y, cand_end_x, cand_end_y, run_end,
    input  ready
  );
  modport sink (
    input  valid, query_start_x, query_start_y, query_end_x, query_end_y,
           cand_start_x, cand_start_y, cand_end_x, cand_end_y, run_end,
    output ready
  );
endinterface

>>> design/scc_result_if.sv
// result channel of the segment crossing counter: pair score and run total
// depends on scc_pkg
interface scc_result_if import scc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SCORE_W-1:0]  pair_score;
  logic [SUM_W-1:0]    running_sum;
  logic                run_done;

  modport source (
    output valid, pair_score, running_sum, run_done,
    input  ready
  );
  modport sink (
    input  valid, pair_score, running_sum, run_done,
    output ready
  );
endinterface

>>> design/scc_cfg_if.sv
// configuration write channel of the segment crossing counter
// depends on scc_pkg
interface scc_cfg_if import scc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SCORE_W-1:0]  collinear_penalty;

  modport source (
    output valid, collinear_penalty,
    input  ready
  );
  modport sink (
    input  valid, collinear_penalty,
    output ready
  );
endinterface

>>> design/scc_orient_stage.sv
// input register and cross product stage of the segment crossing counter
// depends on scc_pkg and scc_pair_if
module scc_orient_stage import scc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  scc_pair_if.sink         pair_i,
  output stage_t           stage_o,
  output logic             stage_valid_o,
  input  logic             stage_ready_i
);

  // point order in the input register: q0, q1, c0, c1
  pt_t [3:0]  pts_q;
  logic       run_end_q;
  logic       a_valid_q;
  logic       a_en;

  stage_t     stage_q;
  stage_t     stage_d;
  logic       b_valid_q;
  logic       b_en;

  assign b_en         = !b_valid_q || stage_ready_i;
  assign a_en         = !a_valid_q || b_en;
  assign pair_i.ready = a_en;

  function automatic diff_t diff(coord_t a, coord_t b);
    return diff_t'({1'b0, a}) - diff_t'({1'b0, b});
  endfunction

  // q lies within the bounding box of p and r
  function automatic logic in_box(pt_t p, pt_t q, pt_t r);
    coord_t xmax;
    coord_t xmin;
    coord_t ymax;
    coord_t ymin;
    xmax = (p.x > r.x) ? p.x : r.x;
    xmin = (p.x < r.x) ? p.x : r.x;
    ymax = (p.y > r.y) ? p.y : r.y;
    ymin = (p.y < r.y) ? p.y : r.y;
    return (q.x <= xmax) && (q.x >= xmin) && (q.y <= ymax) && (q.y >= ymin);
  endfunction

  pt_t [NUM_ORIENT-1:0]  tp;
  pt_t [NUM_ORIENT-1:0]  tq;
  pt_t [NUM_ORIENT-1:0]  tr;

  always_comb begin
    // orientation triples: (q0,q1,c0) (q0,q1,c1) (c0,c1,q0) (c0,c1,q1)
    tp[0] = pts_q[0]; tq[0] = pts_q[1]; tr[0] = pts_q[2];
    tp[1] = pts_q[0]; tq[1] = pts_q[1]; tr[1] = pts_q[3];
    tp[2] = pts_q[2]; tq[2] = pts_q[3]; tr[2] = pts_q[0];
    tp[3] = pts_q[2]; tq[3] = pts_q[3]; tr[3] = pts_q[1];
    stage_d.run_end = run_end_q;
    for (int i = 0; i < NUM_ORIENT; i++) begin
      stage_d.lhs[i] = prod_t'(diff(tq[i].y, tp[i].y)) * prod_t'(diff(tr[i].x, tq[i].x));
      stage_d.rhs[i] = prod_t'(diff(tq[i].x, tp[i].x)) * prod_t'(diff(tr[i].y, tq[i].y));
      // tested endpoint against the box of the other segment
      stage_d.boxed[i] = in_box(tp[i], tr[i], tq[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_q <= pair_i.valid;
      end
      if (b_en) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && pair_i.valid) begin
      pts_q[0] <= '{x: pair_i.query_start_x[COORD_W-1:0], y: pair_i.query_start_y[COORD_W-1:0]};
      pts_q[1] <= '{x: pair_i.query_end_x[COORD_W-1:0],   y: pair_i.query_end_y[COORD_W-1:0]};
      pts_q[2] <= '{x: pair_i.cand_start_x[COORD_W-1:0],  y: pair_i.cand_start_y[COORD_W-1:0]};
      pts_q[3] <= '{x: pair_i.cand_end_x[COORD_W-1:0],    y: pair_i.cand_end_y[COORD_W-1:0]};
      run_end_q <= pair_i.run_end;
    end
    if (b_en && a_valid_q) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o       = stage_q;
  assign stage_valid_o = b_valid_q;

endmodule

>>> design/scc_score_acc.sv
// orientation compare, pair scoring, saturating run total and result register
// depends on scc_pkg and scc_result_if
module scc_score_acc import scc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stage_t              stage_i,
  input  logic                stage_valid_i,
  output logic                stage_ready_o,
  input  logic [SCORE_W-1:0]  penalty_i,
  scc_result_if.source        result_o
);

  logic                out_valid_q;
  logic [SCORE_W-1:0]  score_q;
  logic [SUM_W-1:0]    sum_q;
  logic                done_q;
  logic [SUM_W-1:0]    total_q;
  logic [SUM_W-1:0]    total_d;

  orient_e [NUM_ORIENT-1:0]  ori;
  logic                      crossing;
  logic                      touching;
  logic [SCORE_W-1:0]        score_d;
  logic [SUM_W:0]            sum_wide;
  logic [SUM_W-1:0]          sum_d;
  logic                      out_en;
  logic                      load;

  assign out_en        = !out_valid_q || result_o.ready;
  assign load          = out_en && stage_valid_i;
  assign stage_ready_o = out_en;

  always_comb begin
    touching = 1'b0;
    for (int i = 0; i < NUM_ORIENT; i++) begin
      ori[i] = orient_of(stage_i.lhs[i], stage_i.rhs[i]);
      if (ori[i] == ORI_ZERO && stage_i.boxed[i]) begin
        touching = 1'b1;
      end
    end
    crossing = (ori[0] != ori[1]) && (ori[2] != ori[3]);
    if (crossing) begin
      score_d = SCORE_CROSS;
    end else if (touching) begin
      score_d = penalty_i;
    end else begin
      score_d = SCORE_NONE;
    end
    sum_wide = {1'b0, total_q} + (SUM_W + 1)'(score_d);
    // saturate at all ones
    sum_d    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    total_d  = stage_i.run_end ? '0 : sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      if (out_en) begin
        out_valid_q <= stage_valid_i;
      end
      if (load) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      score_q <= score_d;
      sum_q   <= sum_d;
      done_q  <= stage_i.run_end;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.pair_score  = score_q;
  assign result_o.running_sum = sum_q;
  assign result_o.run_done    = done_q;

  // a closing word leaves a cleared total behind
  a_clear_after_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && stage_i.run_end) |=> (total_q == '0))
    else $error("run total not cleared after run end");

  // the total carried on matches the last shown sum inside a run
  a_total_tracks_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !done_q) |-> (total_q == sum_q))
    else $error("run total differs from shown running sum");

  // saturating add never shows a sum below this word's score
  a_sum_covers_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sum_q >= SUM_W'(score_q)))
    else $error("running sum below pair score");

endmodule

>>> design/segment_crossing_counter.sv
// segment crossing counter: scores segment pairs by orientation tests
// and keeps a saturating per-run total.
// channels: pair_i takes one word per pair (query and candidate endpoints
// plus a run-end mark), result_o gives one word per pair (pair score,
// running sum including this pair, run-done copy of the mark), cfg_i
// writes the collinear penalty, always ready.
// path: a word accepted on pair_i passes the input register, the cross
// product register and the result register before result_o shows it.
// throughput: one word per cycle while result_o is ready; the run total
// adds in the result stage, so consecutive words never wait on each other.
// stalls: each stage fills while the next is held, so up to three words
// sit in flight while result_o is stalled, then pair_i drops ready.
// reset: clears all valid flags and the run total and sets the penalty
// to one. the total clears after every word that carries the run-end mark.
// depends on scc_pkg, the channel interfaces, scc_orient_stage, scc_score_acc
module segment_crossing_counter import scc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  scc_pair_if.sink       pair_i,
  scc_cfg_if.sink        cfg_i,
  scc_result_if.source   result_o
);

  logic [SCORE_W-1:0]  penalty_q;
  stage_t              stage;
  logic                stage_valid;
  logic                stage_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      penalty_q <= PENALTY_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      penalty_q <= cfg_i.collinear_penalty;
    end
  end

  scc_orient_stage u_orient (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pair_i        (pair_i),
    .stage_o       (stage),
    .stage_valid_o (stage_valid),
    .stage_ready_i (stage_ready)
  );

  scc_score_acc u_score (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .stage_valid_i (stage_valid),
    .stage_ready_o (stage_ready),
    .penalty_i     (penalty_q),
    .result_o      (result_o)
  );

endmodule
